[sv/qrq_pkg.sv]
// Shared types and constants for the reciprocal-quadratic quadrature block.
// No dependencies.
package qrq_pkg;

	localparam int unsigned MAX_INTERVALS_DEF = 4096;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned BOUND_W = 24;
	localparam int unsigned RES_W = 32;

	typedef struct packed {
		logic signed [BOUND_W-1:0] lower_bound;
		logic signed [BOUND_W-1:0] upper_bound;
		logic [CNT_W-1:0] interval_count;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] trapezoid_result;
		logic signed [RES_W-1:0] simpson_third_result;
		logic signed [RES_W-1:0] simpson_eighth_result;
		logic trapezoid_error;
		logic simpson_third_error;
		logic simpson_eighth_error;
	} out_item_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SAMPLE,
		OP_ACCUM,
		OP_STEP_DIV,
		OP_SCALE_DIV,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [1:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_point;
		logic err_t;
	} dp_stat_t;

endpackage

[sv/quadrature_of_reciprocal_quadratic_top.sv]
// Top level of the reciprocal-quadratic quadrature block.
// Depends on qrq_pkg, qrq_controller and qrq_datapath.

// The time one item takes grows with the interval count after saturation to
// MAX_INTERVALS and is set by the 64-step serial divider, through which every
// sample's reciprocal, the step size and each of the three final scalings pass.
// A zero count skips the divider and goes straight to the result strobe.
// busy is high from the accepting edge until the result strobe; the result is shown for
// one cycle with done and cannot be held off by the receiver.
module quadrature_of_reciprocal_quadratic_top #(
	parameter int unsigned MAX_INTERVALS = qrq_pkg::MAX_INTERVALS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  qrq_pkg::in_item_t  in_item,
	output logic               done,
	output qrq_pkg::out_item_t out_item
);
	qrq_pkg::dp_cmd_t  cmd;
	qrq_pkg::dp_stat_t stat;

	qrq_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .cmd(cmd),
		.busy(busy), .done(done)
	);

	qrq_datapath #(.MAX_INTERVALS(MAX_INTERVALS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
		.out_item(out_item)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without an item in flight");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_item.trapezoid_error |-> out_item.trapezoid_result == '0)
		else $error("trapezoid result not zero on error");
	a_err_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_item.trapezoid_error |-> out_item.simpson_third_error &&
		out_item.simpson_eighth_error) else $error("error flags inconsistent");
endmodule

[sv/qrq_divider.sv]
// Restoring serial divider: one quotient bit per cycle.
// Depends on nothing.
module qrq_divider #(
	parameter int unsigned NUM_W = 64,
	parameter int unsigned DEN_W = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int unsigned CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign quo   = quo_q;
	assign done  = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q && cnt_q != '0) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule

[sv/qrq_datapath.sv]
// Datapath: sample generation, reciprocal, weighted sums, final scaling.
// Depends on qrq_pkg and qrq_divider.
module qrq_datapath #(
	parameter int unsigned MAX_INTERVALS = qrq_pkg::MAX_INTERVALS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qrq_pkg::in_item_t  in_item,
	input  qrq_pkg::dp_cmd_t   cmd,
	output qrq_pkg::dp_stat_t  stat,
	output qrq_pkg::out_item_t out_item
);
	localparam int unsigned NW = $clog2(MAX_INTERVALS + 1);
	localparam int unsigned SW = 64;
	localparam int unsigned RES_W_L = qrq_pkg::RES_W;

	logic [NW-1:0]          n_q, i_q;
	logic signed [24:0]     a_q, b_q;
	logic signed [25:0]     d_q;
	logic signed [63:0]     h_q, x_q;
	logic [SW-1:0]          st_q, ss_q, se_q;
	logic [1:0]             f_q;
	logic [1:0]             m3_q;
	logic                   ends_q;
	logic                   es_q, ee_q, et_q;
	logic [RES_W_L-1:0]     r0_q, r1_q, r2_q;
	logic [23:0]            m16;
	logic [47:0]            m_sq;
	logic                   div_start;
	logic [63:0]            div_num, div_den, div_quo;
	logic                   div_done;
	logic [25:0]            dm;
	logic [39:0]            fin_sum;
	logic [45:0]            prod_lo_q, prod_hi_q;
	logic [12:0]            n_raw;
	logic [NW-1:0]          n_sat;
	logic [63:0]            sat_mag;

	assign n_raw = in_item.interval_count;
	assign n_sat = (32'(n_raw) > MAX_INTERVALS) ? NW'(MAX_INTERVALS) : NW'(n_raw);
	assign dm = d_q[25] ? 26'(-d_q) : 26'(d_q);

	// Sample in Q.16, endpoints using the bounds directly; m16 is its integer magnitude.
	always_comb begin
		logic signed [63:0] xs;
		logic [63:0]        xm;
		if (cmd.sel == 2'd1) xs = 64'(a_q) <<< 16;
		else if (cmd.sel == 2'd2) xs = 64'(b_q) <<< 16;
		else xs = x_q;
		xm = xs[63] ? 64'(-xs) : 64'(xs);
		m16 = xm[39:16];
	end

	assign m_sq = 48'(m16) * 48'(m16);

	// The scaled sum is formed from two narrower partial products.
	assign fin_sum = (cmd.sel == 2'd0) ? 40'(st_q) : (cmd.sel == 2'd1) ? 40'(ss_q) : 40'(se_q);

	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = 64'd1;
		case (cmd.op)
			qrq_pkg::OP_SAMPLE: begin
				div_start = 1'b1;
				div_num = 64'h0100_0000_0000_0000;
				div_den = 64'h1_0000_0000 + 64'(m_sq);
			end
			qrq_pkg::OP_STEP_DIV: begin
				div_start = 1'b1;
				div_num = 64'(dm) << 16;
				div_den = 64'(n_q);
			end
			qrq_pkg::OP_SCALE_DIV: begin
				div_start = 1'b1;
				div_num = 64'(prod_lo_q) + (64'(prod_hi_q) << 20);
				// Simpson 1/3 divides by three times the count, leaving only a shift.
				div_den = (cmd.sel == 2'd1) ? 64'(n_q) + (64'(n_q) << 1) : 64'(n_q);
			end
			default: ;
		endcase
	end

	qrq_divider #(.NUM_W(64), .DEN_W(64)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	function automatic logic [31:0] sgn_out(input logic neg, input logic [63:0] mag);
		logic [63:0] m;
		m = mag;
		if (neg) begin
			if (m > 64'h8000_0000) m = 64'h8000_0000;
			return 32'(-m);
		end
		if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
		return m[31:0];
	endfunction

	// Remainder modulo three: base-four digits are summed, as four leaves one.
	function automatic logic [1:0] mod3(input logic [NW-1:0] v);
		logic [NW:0] w;
		logic [2:0]  s;
		logic [1:0]  acc;
		w = {1'b0, v};
		acc = 2'd0;
		for (int k = 0; k < NW; k += 2) begin
			s = 3'(acc) + 3'(w[k +: 2]);
			acc = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
		end
		return acc;
	endfunction

	assign sat_mag = div_quo;

	always_ff @(posedge clk) begin
		case (cmd.op)
			qrq_pkg::OP_LOAD: begin
				a_q <= 25'(in_item.lower_bound);
				b_q <= 25'(in_item.upper_bound);
				d_q <= 26'(in_item.upper_bound) - 26'(in_item.lower_bound);
				n_q <= n_sat;
				et_q <= (n_sat == '0);
				es_q <= (n_sat == '0) || n_sat[0];
				ee_q <= (n_sat == '0) || (mod3(n_sat) != 2'd0);
				st_q <= '0; ss_q <= '0; se_q <= '0;
				i_q <= '0; m3_q <= '0; ends_q <= 1'b1;
				r0_q <= '0; r1_q <= '0; r2_q <= '0;
			end
			qrq_pkg::OP_ACCUM: begin
				if (cmd.sel == 2'd0) begin
					st_q <= st_q + (div_quo << 1);
					ss_q <= ss_q + (i_q[0] ? div_quo << 2 : div_quo << 1);
					se_q <= se_q + (m3_q == 2'd0 ? div_quo << 1 : div_quo + (div_quo << 1));
				end else begin
					st_q <= st_q + div_quo;
					ss_q <= ss_q + div_quo;
					se_q <= se_q + div_quo;
				end
				if (cmd.sel == 2'd2 || cmd.sel == 2'd0) begin
					i_q <= i_q + 1'b1;
					m3_q <= (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
					x_q <= x_q + h_q;
				end
			end
			default: ;
		endcase
		if (cmd.op == qrq_pkg::OP_NONE && cmd.sel == 2'd1 && div_done) begin
			// Step size has arrived; signed and first interior point set.
			h_q <= d_q[25] ? -$signed(div_quo) : $signed(div_quo);
			x_q <= (64'(a_q) <<< 16) + (d_q[25] ? -$signed(div_quo) : $signed(div_quo));
			i_q <= NW'(1);
			m3_q <= 2'd1;
		end
		if (cmd.op == qrq_pkg::OP_FINISH) begin
			prod_lo_q <= 46'(dm) * 46'(fin_sum[19:0]);
			prod_hi_q <= 46'(dm) * 46'(fin_sum[39:20]);
		end
		if (cmd.op == qrq_pkg::OP_NONE && cmd.sel == 2'd2 && div_done) begin
			case (f_q)
				2'd0: r0_q <= sgn_out(d_q[25], sat_mag >> 17);
				2'd1: r1_q <= es_q ? '0 : sgn_out(d_q[25], sat_mag >> 16);
				default: r2_q <= ee_q ? '0 : sgn_out(d_q[25], (sat_mag + (sat_mag << 1)) >> 19);
			endcase
		end
		if (cmd.op == qrq_pkg::OP_SCALE_DIV) f_q <= cmd.sel;
	end

	assign stat.div_done = div_done;
	assign stat.last_point = (i_q >= n_q);
	assign stat.err_t = et_q;
	assign out_item.trapezoid_result = r0_q;
	assign out_item.simpson_third_result = r1_q;
	assign out_item.simpson_eighth_result = r2_q;
	assign out_item.trapezoid_error = et_q;
	assign out_item.simpson_third_error = es_q;
	assign out_item.simpson_eighth_error = ee_q;
endmodule

[sv/qrq_controller.sv]
// Controller that sequences the datapath through one item.
// Depends on qrq_pkg.
module qrq_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  qrq_pkg::dp_stat_t stat,
	output qrq_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_HDIV, S_HWAIT, S_EA, S_EAW, S_EB, S_EBW,
		S_PT, S_PTW, S_FIN, S_FDIV, S_FWAIT, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_CHK;
				S_CHK: state_q <= stat.err_t ? S_OUT : S_HDIV;
				S_HDIV: state_q <= S_HWAIT;
				S_HWAIT: if (stat.div_done) state_q <= S_EA;
				S_EA: state_q <= S_EAW;
				S_EAW: if (stat.div_done) state_q <= S_EB;
				S_EB: state_q <= S_EBW;
				S_EBW: if (stat.div_done) state_q <= S_PT;
				S_PT: state_q <= stat.last_point ? S_FIN : S_PTW;
				S_PTW: if (stat.div_done) state_q <= S_PT;
				S_FIN: state_q <= S_FDIV;
				S_FDIV: state_q <= S_FWAIT;
				S_FWAIT: if (stat.div_done) begin
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_FIN;
					end
				end
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.op = qrq_pkg::OP_NONE;
		cmd.sel = 2'd0;
		case (state_q)
			// The item is captured at the accepting edge itself.
			S_IDLE: if (start) cmd.op = qrq_pkg::OP_LOAD;
			S_HDIV: cmd.op = qrq_pkg::OP_STEP_DIV;
			S_HWAIT: cmd.sel = 2'd1;
			S_EA: begin cmd.op = qrq_pkg::OP_SAMPLE; cmd.sel = 2'd1; end
			S_EAW: if (stat.div_done) begin cmd.op = qrq_pkg::OP_ACCUM; cmd.sel = 2'd1; end
			S_EB: begin cmd.op = qrq_pkg::OP_SAMPLE; cmd.sel = 2'd2; end
			S_EBW: if (stat.div_done) begin cmd.op = qrq_pkg::OP_ACCUM; cmd.sel = 2'd3; end
			S_PT: if (!stat.last_point) cmd.op = qrq_pkg::OP_SAMPLE;
			S_PTW: if (stat.div_done) cmd.op = qrq_pkg::OP_ACCUM;
			S_FIN: begin cmd.op = qrq_pkg::OP_FINISH; cmd.sel = k_q; end
			S_FDIV: begin cmd.op = qrq_pkg::OP_SCALE_DIV; cmd.sel = k_q; end
			S_FWAIT: cmd.sel = 2'd2;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule
